FILE: rtl/pdm_pkg.sv
// Shared types and constants for the PWM duty meter.
// No dependencies; imported by every module of the block.
package pdm_pkg;

    localparam int CAP_W      = 16;
    localparam int DUTY_W     = 14;
    localparam int ELAPSED_W  = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = $clog2(DUTY_W);
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    localparam logic [DUTY_W-1:0]    DUTY_FULL   = DUTY_W'(10000);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(100);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN = TIMEOUT_W'(1);

    // Item kinds carried in s_tuser.
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SEL = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PUSH
    } pdm_state_t;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_MUL,
        DP_DIV,
        DP_DONE
    } pdm_div_phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pdm_div_status_t;

endpackage

FILE: rtl/pwm_duty_meter_with_timeout.sv
// Top level of the PWM duty meter with signal-loss timeout.
// Depends on pdm_pkg and instantiates the bit-serial duty unit pdm_div.
//
// Usage. Each input transfer on the s_ channel is either a capture event
// (s_tuser = 0) carrying both timer channel captures, or a one-millisecond tick
// (s_tuser = 1) carrying the sampled pin level. Every input transfer produces
// exactly one output transfer on the m_ channel with the current duty in
// hundredths of a percent and, in m_tuser, a flag that is set when a tick's
// timeout forced the duty to the pin level.
// The cfg_ channel writes the timeout (index 0) and the period channel select
// (index 1); it is always ready and should only be used while the block is idle.
//
// Timing. The block works on one item at a time. For a tick, a zero period or a
// saturated capture the item passes through the execute and push states, and
// m_tvalid rises once the result is pushed; the block then returns to idle for the
// next input transfer. A capture that needs the divide also waits in the divide
// state on the bit-serial multiply and restoring divide in pdm_div (one bit per
// cycle each).
// A result waiting in the output register does not block the next input
// transfer; only the hand-over into that register waits for m_tready, so a
// stalled receiver holds the block in its final step until the result is taken.
//
// Reset (aresetn low, synchronous) clears the duty and the elapsed counter,
// sets the timeout to 100 ms and selects channel one as the period.
module pwm_duty_meter_with_timeout
    import pdm_pkg::*;
#(
    parameter int CAPTURE_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] capture_ch1, [31:16] capture_ch2, [32] pin_level, [39:33] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                  s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [13:0] duty_hundredths, [15:14] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] signal_lost
    output logic                  m_tuser,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Captures are used only up to the timer width, and never beyond the
    // 16 bits the ports carry.
    localparam int OpW = (CAPTURE_WIDTH < CAP_W) ? CAPTURE_WIDTH : CAP_W;

    pdm_state_t state_reg, state_next;

    // Configuration registers.
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 period_sel_reg;

    // Measurement state.
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [DUTY_W-1:0]    duty_reg;

    // The item being worked on.
    logic                 op_reg;
    logic                 pin_reg;
    logic [OpW-1:0]       high_reg;
    logic [OpW-1:0]       period_reg;
    logic                 lost_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic [DUTY_W-1:0]    out_duty_reg;
    logic                 out_lost_reg;

    logic [CAP_W-1:0]     cap1;
    logic [CAP_W-1:0]     cap2;
    logic                 in_xfer;
    logic                 cfg_xfer;
    logic                 div_start;
    logic                 push;
    logic                 needs_div;
    logic [TIMEOUT_W-1:0] limit;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 timed_out;
    logic [DUTY_W-1:0]    div_quotient;
    pdm_div_status_t      div_st;

    assign cap1     = s_tdata[CAP_W-1:0];
    assign cap2     = s_tdata[2*CAP_W-1:CAP_W];
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_xfer = cfg_valid && cfg_ready;

    // A capture needs the divide only when the period is non-zero and the
    // high time is below it; otherwise the result is known at once.
    assign needs_div = (op_reg == OP_CAPTURE) && (period_reg != '0)
                       && (high_reg < period_reg);

    // Timeout test after the saturating increment; a timeout of zero acts as one.
    assign limit       = (timeout_reg == '0) ? TIMEOUT_MIN : timeout_reg;
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign timed_out   = (elapsed_inc > limit);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_EXEC;
            ST_EXEC: state_next = div_start ? ST_DIV : ST_PUSH;
            ST_DIV:  if (div_st.done) state_next = ST_PUSH;
            ST_PUSH: if (push) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_EXEC) && needs_div && !div_st.busy;
        push      = (state_reg == ST_PUSH) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            timeout_reg    <= TIMEOUT_RST;
            period_sel_reg <= 1'b1;
            elapsed_reg    <= '0;
            duty_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_xfer) begin
                case (cfg_index)
                    CFG_TIMEOUT:    timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                    CFG_PERIOD_SEL: period_sel_reg <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (state_reg == ST_EXEC) begin
                if (op_reg == OP_TICK) begin
                    if (timed_out) begin
                        duty_reg    <= pin_reg ? DUTY_FULL : '0;
                        elapsed_reg <= '0;
                    end else begin
                        elapsed_reg <= elapsed_inc;
                    end
                end else begin
                    elapsed_reg <= '0;
                    if ((period_reg != '0) && (high_reg >= period_reg)) begin
                        duty_reg <= DUTY_FULL;
                    end
                end
            end else if ((state_reg == ST_DIV) && div_st.done) begin
                duty_reg <= div_quotient;
            end

            if (push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item and output payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg     <= s_tuser;
            pin_reg    <= s_tdata[2*CAP_W];
            high_reg   <= period_sel_reg ? cap2[OpW-1:0] : cap1[OpW-1:0];
            period_reg <= period_sel_reg ? cap1[OpW-1:0] : cap2[OpW-1:0];
        end
        if (state_reg == ST_EXEC) begin
            lost_reg <= (op_reg == OP_TICK) && timed_out;
        end
        if (push) begin
            out_duty_reg <= duty_reg;
            out_lost_reg <= lost_reg;
        end
    end

    pdm_div #(
        .OPW (OpW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .high     (high_reg),
        .period   (period_reg),
        .quotient (div_quotient),
        .status   (div_st)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W - DUTY_W){1'b0}}, out_duty_reg};
    assign m_tuser   = out_lost_reg;

endmodule

FILE: rtl/pdm_div.sv
// Bit-serial duty unit: forms high*10000 by shift-and-add, then divides by the period.
// Depends on pdm_pkg. Expects high < period, so the quotient fits the duty width.
module pdm_div
    import pdm_pkg::*;
#(
    parameter int OPW = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [OPW-1:0]    high,
    input  logic [OPW-1:0]    period,
    output logic [DUTY_W-1:0] quotient,
    output pdm_div_status_t   status
);

    localparam int AccW = OPW + DUTY_W;

    pdm_div_phase_t   phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [AccW-1:0]  acc_reg;

    logic [AccW-1:0]  addend;
    logic [AccW-1:0]  mul_next;
    logic [OPW:0]     trial;
    logic [OPW:0]     diff;
    logic             fits;
    logic [AccW-1:0]  div_next;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            DP_IDLE: if (start) phase_next = DP_MUL;
            DP_MUL:  if (cnt_reg == '0) phase_next = DP_DIV;
            DP_DIV:  if (cnt_reg == '0) phase_next = DP_DONE;
            DP_DONE: phase_next = DP_IDLE;
            default: phase_next = DP_IDLE;
        endcase
    end

    always_comb begin
        status.busy = (phase_reg != DP_IDLE);
        status.done = (phase_reg == DP_DONE);
    end

    // The multiply walks the constant MSB first; the divide then shifts the
    // product through the low half while the remainder sits in the high half.
    always_comb begin
        addend   = DUTY_FULL[cnt_reg] ? {{DUTY_W{1'b0}}, high} : '0;
        mul_next = {acc_reg[AccW-2:0], 1'b0} + addend;
        trial    = {acc_reg[AccW-1:DUTY_W], acc_reg[DUTY_W-1]};
        fits     = (trial >= {1'b0, period});
        diff     = trial - {1'b0, period};
        div_next = {(fits ? diff[OPW-1:0] : trial[OPW-1:0]),
                    acc_reg[DUTY_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DP_IDLE;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            case (phase_reg)
                DP_IDLE: if (start) cnt_reg <= CNT_W'(DUTY_W - 1);
                DP_MUL:  cnt_reg <= (cnt_reg == '0) ? CNT_W'(DUTY_W - 1) : cnt_reg - 1'b1;
                DP_DIV:  cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            DP_IDLE: if (start) acc_reg <= '0;
            DP_MUL:  acc_reg <= mul_next;
            DP_DIV:  acc_reg <= div_next;
            default: acc_reg <= acc_reg;
        endcase
    end

    assign quotient = acc_reg[DUTY_W-1:0];

endmodule

FILE: rtl/pdm_checker.sv
// Port-level checks for the PWM duty meter, bound to the top level.
// Depends on pdm_pkg for the duty constants.
module pdm_checker
    import pdm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A result offered and not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before its transfer");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while an item is in progress");

    // A duty never exceeds full scale.
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DUTY_W-1:0] <= DUTY_FULL))
        else $error("duty above full scale");

    // A timeout forces the duty to full scale or to zero.
    a_lost_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[DUTY_W-1:0] == DUTY_FULL || m_tdata[DUTY_W-1:0] == '0))
        else $error("signal loss reported with a duty that is not a pin level");

endmodule

bind pwm_duty_meter_with_timeout pdm_checker u_pdm_checker (.*);

FILE: bench/pwm_duty_meter_with_timeout_tb.sv
// Self-checking testbench for the PWM duty meter with signal-loss timeout.
// Depends on pdm_pkg and the pwm_duty_meter_with_timeout RTL; it reads no files.
// A clocked driver and a clocked monitor surround the block and check every reading.
module pwm_duty_meter_with_timeout_tb;
    import pdm_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    // Longest path through the block is the bit-serial multiply and divide, so this covers it comfortably.
    localparam int SETTLE_CYCLES = 48;
    // A correct run ends well before this limit, even with the receiver stalling at
    // a rate of 71 percent.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // One input item: a capture event or a millisecond tick.
    typedef struct packed {
        logic             op;
        logic [CAP_W-1:0] ch1;
        logic [CAP_W-1:0] ch2;
        logic             pin;
    } meter_item_t;

    // One reading returned by the block.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              lost;
    } duty_reading_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [15:0] capture_ch1, [31:16] capture_ch2, [32] pin_level, [39:33] zero
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // [0] operation
    logic                  s_tuser = OP_CAPTURE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [13:0] duty_hundredths, [15:14] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    // [0] signal_lost
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Items waiting to be sent, and readings the block still owes us.
    meter_item_t   send_q[$];
    duty_reading_t reading_q[$];

    // Our own copy of the block's registers and state.
    logic [TIMEOUT_W-1:0] mirror_timeout = TIMEOUT_RST;
    logic                 mirror_period_sel = 1'b1;
    logic [ELAPSED_W-1:0] mirror_elapsed = '0;
    logic [DUTY_W-1:0]    mirror_duty = '0;

    // Idling controls, set by the sequence below and obeyed by the driver.
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        send_hold = 1'b0;
    logic        s_taken = 1'b0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    pwm_duty_meter_with_timeout #(
        .CAPTURE_WIDTH(16)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Works out the reading for one accepted item and advances our copy of the state.
    // A capture clears the elapsed counter and, given a non-zero period, sets the duty
    // to high*10000/period, truncated and capped at full scale. A tick counts up with
    // saturation and, once past the timeout, forces the duty to the pin level.
    function automatic duty_reading_t predict_reading(input meter_item_t item);
        logic [63:0]          period;
        logic [63:0]          high;
        logic [63:0]          ratio;
        logic [TIMEOUT_W-1:0] limit;
        duty_reading_t        reading;
        reading.lost = 1'b0;
        if (item.op == OP_CAPTURE) begin
            period = mirror_period_sel ? 64'(item.ch1) : 64'(item.ch2);
            high   = mirror_period_sel ? 64'(item.ch2) : 64'(item.ch1);
            mirror_elapsed = '0;
            if (period != 64'd0) begin
                ratio = (high * 64'(DUTY_FULL)) / period;
                mirror_duty = (ratio > 64'(DUTY_FULL)) ? DUTY_FULL : ratio[DUTY_W-1:0];
            end
        end else begin
            // A zero timeout behaves as the one-millisecond minimum.
            limit = (mirror_timeout == '0) ? TIMEOUT_MIN : mirror_timeout;
            if (mirror_elapsed != ELAPSED_MAX) begin
                mirror_elapsed = mirror_elapsed + 1'b1;
            end
            if (mirror_elapsed > limit) begin
                mirror_duty = item.pin ? DUTY_FULL : '0;
                mirror_elapsed = '0;
                reading.lost = 1'b1;
            end
        end
        reading.duty = mirror_duty;
        return reading;
    endfunction

    // Driver. Inputs change on the falling edge. An item stays on the bus until it
    // has been taken; only then may the sender idle or present the next one.
    always @(negedge aclk) begin
        meter_item_t item;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (!s_tvalid || s_taken) begin
            if (send_q.size() != 0 && !send_hold && $urandom_range(99) >= send_gap_pct) begin
                item = send_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= item.op;
                s_tdata  <= S_TDATA_W'({item.pin, item.ch2, item.ch1});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor. Everything is sampled on the rising edge, before the block's own
    // registers move. A reading leaving the block is checked before any new
    // expectation is queued, since a result can never come out in the cycle of its
    // own input transfer.
    always @(posedge aclk) begin
        duty_reading_t want;
        meter_item_t   seen;
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (reading_q.size() == 0) begin
                    $display("%0t unexpected reading: duty %0d lost %0b", $time,
                             m_tdata[DUTY_W-1:0], m_tuser);
                    error_count++;
                end else begin
                    want = reading_q.pop_front();
                    if (m_tdata[DUTY_W-1:0] !== want.duty) begin
                        $display("%0t duty mismatch: expected %0d, got %0d", $time,
                                 want.duty, m_tdata[DUTY_W-1:0]);
                        error_count++;
                    end
                    if (m_tuser !== want.lost) begin
                        $display("%0t signal_lost mismatch: expected %0b, got %0b", $time,
                                 want.lost, m_tuser);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIMEOUT: begin
                        mirror_timeout <= cfg_data[TIMEOUT_W-1:0];
                    end
                    CFG_PERIOD_SEL: begin
                        mirror_period_sel <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                seen.op  = s_tuser;
                seen.ch1 = s_tdata[CAP_W-1:0];
                seen.ch2 = s_tdata[2*CAP_W-1:CAP_W];
                seen.pin = s_tdata[2*CAP_W];
                reading_q.push_back(predict_reading(seen));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pwm_duty_meter_with_timeout_tb: errors");
            $finish;
        end
    end

    // Queues a capture event; the pin level is ignored on captures, so it is random.
    task automatic push_capture(input logic [CAP_W-1:0] ch1, input logic [CAP_W-1:0] ch2);
        meter_item_t item;
        item = '{op: OP_CAPTURE, ch1: ch1, ch2: ch2, pin: 1'($urandom)};
        send_q.push_back(item);
    endtask

    // Queues a run of ticks; the capture fields are ignored on ticks, so they are random.
    task automatic push_ticks(input int count, input logic pin);
        meter_item_t item;
        for (int k = 0; k < count; k++) begin
            item = '{op: OP_TICK, ch1: CAP_W'($urandom), ch2: CAP_W'($urandom), pin: pin};
            send_q.push_back(item);
        end
    endtask

    // A capture as a real PWM input would give it: mostly a high time within the
    // period, sometimes an overlong high time, now and then a zero period.
    task automatic push_pwm_capture();
        logic [CAP_W-1:0] period;
        logic [CAP_W-1:0] high;
        int unsigned      pick;
        pick = $urandom_range(99);
        period = CAP_W'($urandom_range(1, 65535) >> $urandom_range(0, 15));
        if (period == '0) begin
            period = CAP_W'(1);
        end
        if (pick < 80) begin
            high = CAP_W'($urandom_range(0, period));
        end else if (pick < 90) begin
            high = CAP_W'($urandom_range(period, 65535));
        end else begin
            period = '0;
            high = CAP_W'($urandom);
        end
        if (mirror_period_sel) begin
            push_capture(period, high);
        end else begin
            push_capture(high, period);
        end
    endtask

    // Random traffic for the current register setting. Most of it is bursts of ticks
    // around the timeout followed by a capture, so that timeouts fire often; the rest
    // is single items with every field random.
    task automatic queue_traffic(input int count);
        int          added;
        int          burst;
        int          limit;
        meter_item_t item;
        added = 0;
        limit = (mirror_timeout == '0) ? 1 : int'(mirror_timeout);
        while (added < count) begin
            if ($urandom_range(99) < 75) begin
                burst = $urandom_range(0, 2 * limit + 2);
                for (int k = 0; k < burst; k++) begin
                    push_ticks(1, 1'($urandom));
                end
                push_pwm_capture();
                added += burst + 1;
            end else begin
                item = '{op: 1'($urandom), ch1: CAP_W'($urandom), ch2: CAP_W'($urandom),
                         pin: 1'($urandom)};
                send_q.push_back(item);
                added++;
            end
        end
    endtask

    // Waits until every queued item has been sent and every reading has come back,
    // then lets the block settle.
    task automatic drain_block();
        while (send_q.size() != 0 || s_tvalid || reading_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Writes both registers; only called while the block is idle. The upper bits of
    // the period select write are junk that the block must ignore.
    task automatic set_registers(input logic [TIMEOUT_W-1:0] timeout, input logic sel);
        write_register(CFG_TIMEOUT, CFG_DATA_W'(timeout));
        write_register(CFG_PERIOD_SEL, CFG_DATA_W'({15'($urandom), sel}));
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset settings, with the sender idling at a rate of
        // 32 percent and the receiver stalling at 71 percent.
        send_gap_pct   = 32;
        recv_stall_pct = 71;
        push_capture(16'd0, 16'd5);          // zero period keeps the reset duty
        push_capture(16'd1000, 16'd250);     // a plain quarter duty
        push_capture(16'hFFFF, 16'hFFFF);    // full scale
        push_capture(16'hFFFF, 16'd0);       // never high
        push_capture(16'd1, 16'hFFFF);       // high time above period saturates
        push_capture(16'd0, 16'd0);          // zero period again, duty unchanged
        push_capture(16'd3, 16'd1);          // truncation of a third
        push_capture(16'hFFFF, 16'd1);       // smallest ratio truncates to zero
        push_capture(16'hFFFF, 16'h8000);    // just over a half
        // The timeout fires on the tick that takes the counter past the limit.
        push_ticks(100, 1'b1);
        push_ticks(1, 1'b1);
        push_capture(16'd1000, 16'd250);
        push_ticks(101, 1'b0);
        drain_block();

        // A zero timeout acts as one millisecond; channels swapped.
        set_registers('0, 1'b0);
        push_capture(16'd250, 16'd1000);
        push_capture(16'd5, 16'd0);          // swapped zero period still clears the counter
        push_ticks(2, 1'b1);
        push_ticks(2, 1'b0);
        push_capture(16'hFFFF, 16'd1);
        push_capture(16'd0, 16'd0);
        drain_block();

        // The shortest legal timeout, period back on channel one.
        set_registers(TIMEOUT_MIN, 1'b1);
        push_capture(16'd40, 16'd400);
        push_ticks(3, 1'b1);
        drain_block();

        // First random phase. Midway the sender is held back until every reading
        // has come home, then released with items still queued.
        set_registers(16'd4, 1'b1);
        queue_traffic(150);
        while (send_q.size() > 75) begin
            @(posedge aclk);
        end
        send_hold = 1'b1;
        while (s_tvalid || reading_q.size() != 0) begin
            @(posedge aclk);
        end
        send_hold = 1'b0;
        queue_traffic(150);
        drain_block();

        // Second random phase with the idling the other way round.
        send_gap_pct   = 71;
        recv_stall_pct = 32;
        set_registers(16'd23, 1'b0);
        queue_traffic(350);
        drain_block();

        // No idling from here on. At the largest timeout a run of ticks never fires;
        // lowering the timeout below the count reached then fires on the next tick.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_registers(16'hFFFF, 1'b1);
        push_capture(16'd800, 16'd200);
        push_ticks(40, 1'($urandom));
        drain_block();
        set_registers(16'd30, 1'b1);
        push_ticks(2, 1'b1);
        drain_block();

        // Third random phase at a random short timeout and channel choice.
        set_registers(TIMEOUT_W'($urandom_range(1, 12)), 1'($urandom));
        queue_traffic(350);
        drain_block();

        if (reading_q.size() != 0) begin
            $display("%0t %0d readings never arrived", $time, reading_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("pwm_duty_meter_with_timeout_tb: clean");
        end else begin
            $display("pwm_duty_meter_with_timeout_tb: errors");
        end
        $finish;
    end

endmodule
